// ===== rtl/glos_pkg.sv =====
// Shared types and constants of the grid line-of-sight checker.
// Used by glos_ctrl, glos_dp and grid_line_of_sight_check_unit; no dependencies.
`default_nettype none

package glos_pkg;

    localparam int S_TDATA_W = 152;
    localparam int M_TDATA_W = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_WIDE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_DEEP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SIDE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z   = 3'd4;

    localparam logic [8:0]  RST_CELLS  = 9'd256;
    localparam logic [23:0] RST_INV    = 24'd655360;

    localparam logic signed [63:0] HALF_Q32 = 64'sh0000_0000_8000_0000;

    // coordinate sequence: four multiplies, the last clamp in the cycle after the last multiply
    localparam logic [2:0] COORD_LAST = 3'd4;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_COORD,
        ST_SETUP,
        ST_MULT,
        ST_READ,
        ST_CHECK
    } state_t;

    typedef struct packed {
        logic       clear;
        logic       wr_item;
        logic       load;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       clamp_en;
        logic [1:0] clamp_sel;
        logic       setup;
        logic       mul_step;
        logic       walk_step;
        logic       push;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic mul_done;
        logic walk_done;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// ===== rtl/glos_ctrl.sv =====
// Controller state machine of the grid line-of-sight checker.
// Depends on glos_pkg; drives glos_dp through cmd_t and reads sts_t.
`default_nettype none

module glos_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    input  wire logic          s_action,
    output logic               s_tready,
    output glos_pkg::cmd_t     cmd,
    input  wire glos_pkg::sts_t sts
);

    glos_pkg::state_t state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= glos_pkg::ST_CLEAR;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            glos_pkg::ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (sts.clear_last) begin
                    state_next = glos_pkg::ST_IDLE;
                end
            end
            glos_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cnt_next = '0;
                if (s_tvalid && s_action) begin
                    cmd.load   = 1'b1;
                    state_next = glos_pkg::ST_COORD;
                end else if (s_tvalid) begin
                    cmd.wr_item = 1'b1;
                end
            end
            glos_pkg::ST_COORD: begin
                cmd.mul_en    = (cnt_reg != glos_pkg::COORD_LAST);
                cmd.mul_sel   = cnt_reg[1:0];
                cmd.clamp_en  = (cnt_reg != 3'd0);
                cmd.clamp_sel = 2'(cnt_reg - 3'd1);
                cnt_next      = cnt_reg + 3'd1;
                if (cnt_reg == glos_pkg::COORD_LAST) begin
                    state_next = glos_pkg::ST_SETUP;
                end
            end
            glos_pkg::ST_SETUP: begin
                cmd.setup  = 1'b1;
                state_next = glos_pkg::ST_MULT;
            end
            glos_pkg::ST_MULT: begin
                if (sts.mul_done) begin
                    state_next = glos_pkg::ST_READ;
                end else begin
                    cmd.mul_step = 1'b1;
                end
            end
            glos_pkg::ST_READ: begin
                state_next = glos_pkg::ST_CHECK;
            end
            glos_pkg::ST_CHECK: begin
                if (sts.walk_done) begin
                    if (sts.out_free) begin
                        cmd.push   = 1'b1;
                        state_next = glos_pkg::ST_IDLE;
                    end
                end else begin
                    cmd.walk_step = 1'b1;
                end
            end
            default: begin
                state_next = glos_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/glos_dp.sv =====
// Datapath of the grid line-of-sight checker: config registers, occupancy memory,
// coordinate mapping, serial products, cell walk and result register. Uses glos_pkg.
`default_nettype none

module glos_dp #(
    parameter int MAX_CELLS_WIDE = 256,
    parameter int MAX_CELLS_DEEP = 256,
    parameter int FRAC_BITS      = 16
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [glos_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [glos_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic [glos_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire glos_pkg::cmd_t                   cmd,
    output glos_pkg::sts_t                        sts,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [glos_pkg::M_TDATA_W-1:0]        m_tdata
);

    localparam int DEPTH = MAX_CELLS_WIDE * MAX_CELLS_DEEP;
    localparam int AW    = $clog2(DEPTH);
    localparam int XB    = $clog2(MAX_CELLS_WIDE);
    localparam int ZB    = $clog2(MAX_CELLS_DEEP);
    localparam int MAXN  = (MAX_CELLS_WIDE > MAX_CELLS_DEEP) ? MAX_CELLS_WIDE : MAX_CELLS_DEEP;
    localparam int NB    = $clog2(MAXN + 1);
    localparam int GW    = NB + FRAC_BITS;
    localparam int DW    = GW + 1;
    localparam int PW    = DW + GW;
    localparam int SH    = 32 - FRAC_BITS;

    // ---------------- configuration registers
    logic [8:0]  cw_reg, cd_reg;
    logic [23:0] inv_reg;
    logic [31:0] ctrx_reg, ctrz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cw_reg   <= glos_pkg::RST_CELLS;
            cd_reg   <= glos_pkg::RST_CELLS;
            inv_reg  <= glos_pkg::RST_INV;
            ctrx_reg <= '0;
            ctrz_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                glos_pkg::CFG_CELLS_WIDE: cw_reg   <= cfg_data[8:0];
                glos_pkg::CFG_CELLS_DEEP: cd_reg   <= cfg_data[8:0];
                glos_pkg::CFG_INV_SIDE:   inv_reg  <= cfg_data[23:0];
                glos_pkg::CFG_CENTER_X:   ctrx_reg <= cfg_data;
                glos_pkg::CFG_CENTER_Z:   ctrz_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // counts in use: zero acts as one, oversize acts as the maximum
    logic [NB-1:0] nx, nz;
    always_comb begin
        if (cw_reg == 9'd0) nx = NB'(1);
        else if (int'(cw_reg) > MAX_CELLS_WIDE) nx = NB'(MAX_CELLS_WIDE);
        else nx = NB'(cw_reg);
        if (cd_reg == 9'd0) nz = NB'(1);
        else if (int'(cd_reg) > MAX_CELLS_DEEP) nz = NB'(MAX_CELLS_DEEP);
        else nz = NB'(cd_reg);
    end

    // ---------------- input fields
    logic [7:0]  in_cx, in_cz;
    logic        in_occ;
    assign in_cx  = s_tdata[7:0];
    assign in_cz  = s_tdata[15:8];
    assign in_occ = s_tdata[16];

    logic [31:0] pt_reg [4];  // from_x, from_z, to_x, to_z

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            pt_reg[0] <= s_tdata[48:17];
            pt_reg[1] <= s_tdata[80:49];
            pt_reg[2] <= s_tdata[112:81];
            pt_reg[3] <= s_tdata[144:113];
        end
    end

    // ---------------- coordinate mapping: multiply stage, then clamp stage
    logic [31:0]        mul_pos, mul_ctr;
    logic signed [32:0] off;
    logic signed [57:0] prod_next, prod_reg;

    assign mul_pos   = pt_reg[cmd.mul_sel];
    assign mul_ctr   = cmd.mul_sel[0] ? ctrz_reg : ctrx_reg;
    assign off       = $signed({mul_pos[31], mul_pos}) - $signed({mul_ctr[31], mul_ctr});
    assign prod_next = off * $signed({1'b0, inv_reg});

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_reg <= prod_next;
        end
    end

    logic [NB-1:0]      cl_n;
    logic [NB:0]        cl_mid;
    logic signed [63:0] cl_f, cl_hi, cl_c;
    logic [63:0]        cl_u;
    logic [GW-1:0]      g_reg [4];

    always_comb begin
        cl_n   = cmd.clamp_sel[0] ? nz : nx;
        cl_mid = ({1'b0, cl_n} + (NB+1)'(1)) >> 1;
        cl_f   = {{6{prod_reg[57]}}, prod_reg} + $signed({(31 - NB)'(0), cl_mid, 32'd0});
        cl_hi  = $signed({(32 - NB)'(0), cl_n, 32'd0}) - glos_pkg::HALF_Q32;
        if (cl_f < -glos_pkg::HALF_Q32) cl_c = -glos_pkg::HALF_Q32;
        else if (cl_f > cl_hi) cl_c = cl_hi;
        else cl_c = cl_f;
        cl_u = 64'(cl_c + glos_pkg::HALF_Q32);
    end

    always_ff @(posedge aclk) begin
        if (cmd.clamp_en) begin
            g_reg[cmd.clamp_sel] <= cl_u[SH +: GW];
        end
    end

    // ---------------- axis setup
    function automatic logic [NB-1:0] cell_lim(input logic [GW-1:0] g, input logic [NB-1:0] n);
        logic [NB-1:0] c;
        c = g[GW-1:FRAC_BITS];
        return (c > n - NB'(1)) ? n - NB'(1) : c;
    endfunction

    logic [NB-1:0] sx0, sx1, sz0, sz1;
    logic [DW-1:0] dist_x, dist_z;
    logic [GW-1:0] spd_x, spd_z;

    always_comb begin
        sx0 = cell_lim(g_reg[0], nx);
        sx1 = cell_lim(g_reg[2], nx);
        sz0 = cell_lim(g_reg[1], nz);
        sz1 = cell_lim(g_reg[3], nz);
        if (g_reg[2] > g_reg[0]) begin
            spd_x  = g_reg[2] - g_reg[0];
            dist_x = {({1'b0, sx0} + (NB+1)'(1)), {FRAC_BITS{1'b0}}} - DW'(g_reg[0]);
        end else begin
            spd_x  = g_reg[0] - g_reg[2];
            dist_x = DW'(g_reg[0]) - DW'({sx0, {FRAC_BITS{1'b0}}});
        end
        if (g_reg[3] > g_reg[1]) begin
            spd_z  = g_reg[3] - g_reg[1];
            dist_z = {({1'b0, sz0} + (NB+1)'(1)), {FRAC_BITS{1'b0}}} - DW'(g_reg[1]);
        end else begin
            spd_z  = g_reg[1] - g_reg[3];
            dist_z = DW'(g_reg[1]) - DW'({sz0, {FRAC_BITS{1'b0}}});
        end
    end

    // ---------------- walk state and serial products tx = dist_x*spd_z, tz = dist_z*spd_x
    logic [XB-1:0] cx_reg, lastx_reg;
    logic [ZB-1:0] cz_reg, lastz_reg;
    logic          movx_reg, posx_reg, movz_reg, posz_reg;
    logic [GW-1:0] sx_reg, sz_reg;
    logic [PW-1:0] tx_reg, tz_reg, ax_reg, az_reg;
    logic [GW-1:0] bx_reg, bz_reg;

    logic          mv_x;
    logic [XB-1:0] cx_nx;
    logic [ZB-1:0] cz_nx;
    logic          occ;

    assign mv_x  = !movz_reg ? 1'b1 : (!movx_reg ? 1'b0 : (tx_reg < tz_reg));
    assign cx_nx = posx_reg ? cx_reg + XB'(1) : cx_reg - XB'(1);
    assign cz_nx = posz_reg ? cz_reg + ZB'(1) : cz_reg - ZB'(1);

    always_ff @(posedge aclk) begin
        if (cmd.setup) begin
            cx_reg    <= XB'(sx0);
            lastx_reg <= XB'(sx1);
            cz_reg    <= ZB'(sz0);
            lastz_reg <= ZB'(sz1);
            movx_reg  <= (g_reg[2] != g_reg[0]);
            posx_reg  <= (g_reg[2] > g_reg[0]);
            movz_reg  <= (g_reg[3] != g_reg[1]);
            posz_reg  <= (g_reg[3] > g_reg[1]);
            sx_reg    <= spd_x;
            sz_reg    <= spd_z;
            tx_reg    <= '0;
            tz_reg    <= '0;
            ax_reg    <= PW'(dist_x);
            az_reg    <= PW'(dist_z);
            bx_reg    <= spd_z;
            bz_reg    <= spd_x;
        end else if (cmd.mul_step) begin
            if (bx_reg[0]) tx_reg <= tx_reg + ax_reg;
            if (bz_reg[0]) tz_reg <= tz_reg + az_reg;
            ax_reg <= ax_reg << 1;
            az_reg <= az_reg << 1;
            bx_reg <= bx_reg >> 1;
            bz_reg <= bz_reg >> 1;
        end else if (cmd.walk_step) begin
            // advance the moving axis one cell, its boundary distance by one cell
            if (mv_x) begin
                cx_reg <= cx_nx;
                tx_reg <= tx_reg + (PW'(sz_reg) << FRAC_BITS);
            end else begin
                cz_reg <= cz_nx;
                tz_reg <= tz_reg + (PW'(sx_reg) << FRAC_BITS);
            end
        end
    end

    // ---------------- occupancy memory: one write, one registered read per cycle
    logic          mem [DEPTH];
    logic          mem_q;
    logic [AW-1:0] clr_reg;
    logic          we, wd;
    logic [AW-1:0] wa, ra;
    logic [XB-1:0] rx;
    logic [ZB-1:0] rz;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (cmd.clear) begin
            clr_reg <= clr_reg + AW'(1);
        end
    end

    always_comb begin
        if (cmd.clear) begin
            we = 1'b1;
            wa = clr_reg;
            wd = 1'b0;
        end else begin
            we = cmd.wr_item && (int'(in_cx) < MAX_CELLS_WIDE) && (int'(in_cz) < MAX_CELLS_DEEP);
            wa = AW'(int'(in_cz) * MAX_CELLS_WIDE + int'(in_cx));
            wd = in_occ;
        end
        // read ahead at the cell the walk is moving to
        rx = (cmd.walk_step && mv_x) ? cx_nx : cx_reg;
        rz = (cmd.walk_step && !mv_x) ? cz_nx : cz_reg;
        ra = AW'(int'(rz) * MAX_CELLS_WIDE + int'(rx));
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        mem_q <= mem[ra];
    end

    assign occ = mem_q;

    // ---------------- result register
    logic m_valid_reg, m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.push) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            m_data_reg <= !occ;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(glos_pkg::M_TDATA_W - 1)'(0), m_data_reg};

    assign sts.clear_last = (clr_reg == AW'(DEPTH - 1));
    assign sts.mul_done   = (bx_reg == '0) && (bz_reg == '0);
    assign sts.walk_done  = occ || (!movx_reg && !movz_reg)
                            || (mv_x ? (cx_reg == lastx_reg) : (cz_reg == lastz_reg));
    assign sts.out_free   = !m_valid_reg || m_tready;

endmodule

`default_nettype wire

// ===== rtl/grid_line_of_sight_check_unit.sv =====
// Top level of the grid line-of-sight checker: joins controller and datapath.
// Depends on glos_pkg, glos_ctrl and glos_dp.
//
//   channel   dir  handshake              payload
//   s_        in   s_tvalid / s_tready    s_tuser action, s_tdata cell and segment fields
//   m_        out  m_tvalid / m_tready    m_tdata unobstructed
//   cfg_      in   cfg_wr_en              cfg_index, cfg_data
//
// A write item is taken while idle and updates the grid. A query item goes through coordinate
// mapping (one shared 33x25 multiplier), a setup step, bit-serial boundary products (the
// last step only sees them done), a read step and one step per visited cell (one grid
// read each): s_tready stays low until the result of a query is pushed.
// After reset a clearing pass zeroes all MAX_CELLS_WIDE*MAX_CELLS_DEEP grid cells
// (65536 at default size), with s_tready low; configuration writes are taken throughout.
// A stalled result holds in the output register; the walk waits on its last cell.
`default_nettype none

module grid_line_of_sight_check_unit #(
    parameter int MAX_CELLS_WIDE = 256,
    parameter int MAX_CELLS_DEEP = 256,
    parameter int FRAC_BITS      = 16
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // [0] action
    input  wire logic                             s_tuser,
    // [7:0] cell_x, [15:8] cell_z, [16] occupied_in, [48:17] from_x,
    // [80:49] from_z, [112:81] to_x, [144:113] to_z, [151:145] zero
    input  wire logic [glos_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [0] unobstructed, [7:1] zero
    output logic [glos_pkg::M_TDATA_W-1:0]        m_tdata,
    input  wire logic                             cfg_wr_en,
    input  wire logic [glos_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [glos_pkg::CFG_DATA_W-1:0]  cfg_data
);

    glos_pkg::cmd_t cmd;
    glos_pkg::sts_t sts;

    glos_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_action (s_tuser),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    glos_dp #(
        .MAX_CELLS_WIDE (MAX_CELLS_WIDE),
        .MAX_CELLS_DEEP (MAX_CELLS_DEEP),
        .FRAC_BITS      (FRAC_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // a query holds the input side until its walk is done
    a_query_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser |=> !s_tready)
        else $error("input ready while a query is in flight");

    // a result only appears from a walk, never while idle
    a_result_from_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result raised while idle");

    // a write item produces no result
    a_write_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tuser && !m_tvalid |=> !m_tvalid)
        else $error("write item produced a result");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for grid_line_of_sight_check_unit: drives cell writes and
// line-of-sight queries on the stream input and checks each answer against a local grid
// walker. Depends on glos_pkg and the RTL of the block.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_W     = 256;
    localparam int GRID_D     = 256;
    localparam int FRAC       = 16;
    localparam int SETTLE     = 700;        // longest query walk plus margin
    localparam int LIMIT      = 4000000;
    localparam int HOLD_LONG  = 3000;
    localparam int PHASES     = 10;
    localparam int PHASE_LEN  = 70;
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;
    localparam logic [31:0] M1    = 32'h0001_0000;   // one metre, Q16.16
    localparam logic [31:0] M1N   = 32'hFFFF_0000;
    localparam logic [31:0] W_MIN = 32'h8000_0000;
    localparam logic [31:0] W_MAX = 32'h7FFF_FFFF;

    typedef struct {
        logic        act;
        logic [7:0]  cx;
        logic [7:0]  cz;
        logic        occ;
        logic [31:0] fx;
        logic [31:0] fz;
        logic [31:0] tx;
        logic [31:0] tz;
        bit          known;    // answer typed into the table
        logic        answer;
    } los_item_t;

    logic                             aclk;
    logic                             aresetn;
    logic                             s_tvalid;
    logic                             s_tready;
    logic                             s_tuser;
    logic [glos_pkg::S_TDATA_W-1:0]   s_tdata;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [glos_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                             cfg_wr_en;
    logic [glos_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [glos_pkg::CFG_DATA_W-1:0]  cfg_data;

    grid_line_of_sight_check_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Local copy of the block state
    bit          occ_map [GRID_W*GRID_D];
    logic [8:0]  cur_wide = glos_pkg::RST_CELLS;
    logic [8:0]  cur_deep = glos_pkg::RST_CELLS;
    logic [23:0] cur_inv  = glos_pkg::RST_INV;
    logic [31:0] cur_cx   = '0;
    logic [31:0] cur_cz   = '0;

    logic        sight_q [$];   // answers still owed by the block
    int          errors = 0;
    int          answers_seen = 0;
    longint      cycle_cnt = 0;

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    // Abort on a hang
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int unsigned used_cells(logic [8:0] raw, int unsigned maxv);
        if (raw == 0)
            return 1;
        if (raw > maxv)
            return maxv;
        return raw;
    endfunction

    // Shifted fractional cell coordinate (clamped, plus half a cell), Q.FRAC
    function automatic longint unsigned grid_pos(logic [31:0] p, logic [31:0] c,
                                                 int unsigned n);
        longint off, f, hi, half;
        half = 64'sh8000_0000;
        off  = longint'($signed(p)) - longint'($signed(c));
        f    = off * longint'({8'd0, cur_inv}) + (longint'((n + 1) >> 1) <<< 32);
        hi   = (longint'(n) <<< 32) - half;
        if (f < -half)
            f = -half;
        if (f > hi)
            f = hi;
        return longint'(f + half) >> (32 - FRAC);
    endfunction

    function automatic int unsigned cell_index(longint unsigned g, int unsigned n);
        longint unsigned c;
        c = g >> FRAC;
        if (c > n - 1)
            c = n - 1;
        return int'(c);
    endfunction

    // Walk the cells crossed by the segment; axis 0 is x, axis 1 is z
    function automatic logic predict_sight(logic [31:0] fx, logic [31:0] fz,
                                           logic [31:0] tx, logic [31:0] tz);
        int unsigned     n [2];
        longint unsigned g0 [2], g1 [2], bdist [2], speed [2];
        int unsigned     cidx [2], last [2];
        int              dir [2];
        int              mv;
        n[0]  = used_cells(cur_wide, GRID_W);
        n[1]  = used_cells(cur_deep, GRID_D);
        g0[0] = grid_pos(fx, cur_cx, n[0]);
        g1[0] = grid_pos(tx, cur_cx, n[0]);
        g0[1] = grid_pos(fz, cur_cz, n[1]);
        g1[1] = grid_pos(tz, cur_cz, n[1]);
        for (int a = 0; a < 2; a++) begin
            cidx[a] = cell_index(g0[a], n[a]);
            last[a] = cell_index(g1[a], n[a]);
            if (g1[a] > g0[a]) begin
                dir[a]   = 1;
                speed[a] = g1[a] - g0[a];
                bdist[a] = (longint'(cidx[a] + 1) << FRAC) - g0[a];
            end else if (g1[a] < g0[a]) begin
                dir[a]   = -1;
                speed[a] = g0[a] - g1[a];
                bdist[a] = g0[a] - (longint'(cidx[a]) << FRAC);
            end else begin
                dir[a]   = 0;
                speed[a] = 0;
                bdist[a] = 0;
            end
        end
        forever begin
            if (occ_map[cidx[1] * GRID_W + cidx[0]])
                return 1'b0;
            if (dir[0] == 0 && dir[1] == 0)
                return 1'b1;
            if (dir[0] == 0)
                mv = 1;
            else if (dir[1] == 0)
                mv = 0;
            else
                mv = (bdist[0] * speed[1] < bdist[1] * speed[0]) ? 0 : 1;  // tie steps z
            if (cidx[mv] == last[mv])
                return 1'b1;
            cidx[mv] = (dir[mv] > 0) ? cidx[mv] + 1 : cidx[mv] - 1;
            bdist[mv] += longint'(1) << FRAC;
        end
    endfunction

    function automatic los_item_t row(logic act, logic [7:0] cx, logic [7:0] cz,
                                      logic occ, logic [31:0] fx, logic [31:0] fz,
                                      logic [31:0] tx, logic [31:0] tz,
                                      bit known, logic answer);
        los_item_t r;
        r = '{act, cx, cz, occ, fx, fz, tx, tz, known, answer};
        return r;
    endfunction

    // World coordinate somewhere on or just beyond the grid along one axis
    function automatic logic [31:0] near_world(logic [31:0] centre, int unsigned n);
        int     span;
        longint k;
        span = (n + 4) << FRAC;
        k    = longint'($urandom_range(0, span)) - (span >> 1);
        if (cur_inv == 0)
            return $urandom;
        return centre + 32'((k <<< 16) / longint'({8'd0, cur_inv}));
    endfunction

    function automatic los_item_t random_item();
        los_item_t   it;
        int unsigned nw, nd, r;
        nw = used_cells(cur_wide, GRID_W);
        nd = used_cells(cur_deep, GRID_D);
        it = row(ACT_QUERY, 8'($urandom), 8'($urandom), 1'($urandom), $urandom, $urandom,
                 $urandom, $urandom, 0, 1'b0);
        r  = $urandom_range(0, 99);
        if (r < 35) begin
            it.act = ACT_WRITE;
            it.occ = ($urandom_range(0, 99) < 30);
            if ($urandom_range(0, 99) < 80) begin
                it.cx = 8'($urandom_range(0, (nw + 1 > 255) ? 255 : nw + 1));
                it.cz = 8'($urandom_range(0, (nd + 1 > 255) ? 255 : nd + 1));
            end
        end else if (r < 88) begin
            it.fx = near_world(cur_cx, nw);
            it.tx = near_world(cur_cx, nw);
            it.fz = near_world(cur_cz, nd);
            it.tz = near_world(cur_cz, nd);
            r = $urandom_range(0, 99);
            if (r < 8)
                it.tx = it.fx;          // no motion along x
            else if (r < 16)
                it.tz = it.fz;          // no motion along z
            else if (r < 21) begin
                it.tx = it.fx;          // zero-length segment
                it.tz = it.fz;
            end
        end
        return it;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    // Offer one item, wait for the handshake, then update the local state
    task automatic offer(los_item_t it, int gap);
        s_tvalid <= 1'b1;
        s_tuser  <= it.act;
        s_tdata  <= {7'd0, it.tz, it.tx, it.fz, it.fx, it.occ, it.cz, it.cx};
        do
            @(posedge aclk);
        while (!s_tready);
        if (it.act == ACT_QUERY)
            sight_q.push_back(it.known ? it.answer
                                       : predict_sight(it.fx, it.fz, it.tx, it.tz));
        else
            occ_map[int'(it.cz) * GRID_W + int'(it.cx)] = it.occ;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Wait for all answers, then let a trailing walk finish
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sight_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Write all five registers back to back, holding the enable high throughout
    task automatic program_regs(logic [31:0] wide, logic [31:0] deep, logic [31:0] inv,
                                logic [31:0] cx, logic [31:0] cz);
        logic [glos_pkg::CFG_IDX_W-1:0] idx [5];
        logic [31:0]                    val [5];
        idx = '{glos_pkg::CFG_CELLS_WIDE, glos_pkg::CFG_CELLS_DEEP, glos_pkg::CFG_INV_SIDE,
                glos_pkg::CFG_CENTER_X, glos_pkg::CFG_CENTER_Z};
        val = '{wide, deep, inv, cx, cz};
        for (int i = 0; i < 5; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge aclk);
            case (idx[i])
                glos_pkg::CFG_CELLS_WIDE: cur_wide = val[i][8:0];
                glos_pkg::CFG_CELLS_DEEP: cur_deep = val[i][8:0];
                glos_pkg::CFG_INV_SIDE:   cur_inv  = val[i][23:0];
                glos_pkg::CFG_CENTER_X:   cur_cx   = val[i];
                glos_pkg::CFG_CENTER_Z:   cur_cz   = val[i];
                default: ;
            endcase
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Check each answer against the oldest owed one
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            answers_seen <= answers_seen + 1;
            if (sight_q.size() == 0) begin
                errors <= errors + 1;
                $display("%0t: unexpected answer, expected none actual unobstructed=%0b",
                         $time, m_tdata[0]);
            end else if (sight_q[0] !== m_tdata[0]) begin
                errors <= errors + 1;
                $display("%0t: unobstructed mismatch, expected %0b actual %0b",
                         $time, sight_q[0], m_tdata[0]);
                void'(sight_q.pop_front());
            end else begin
                void'(sight_q.pop_front());
            end
        end
    end

    // Result side: random stalls, one long hold-off to back the block up
    initial begin
        bit held;
        held = 0;
        m_tready <= 1'b0;
        @(posedge aresetn);
        forever begin
            if (!held && answers_seen >= 30) begin
                held = 1;
                m_tready <= 1'b0;
                repeat (HOLD_LONG) @(posedge aclk);
            end else if ($urandom_range(0, 99) < 60) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end else begin
                m_tready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge aclk);
            end
        end
    end

    initial begin
        los_item_t   dir_tab [$];
        los_item_t   it;
        logic [31:0] w, d, inv, cx, cz;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tuser   <= 1'b0;
        s_tdata   <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed rows at reset settings: 256x256 grid, 10 cells/m, centre cell 128 at 0
        dir_tab.push_back(row(ACT_QUERY, 0, 0, 0, 0, 0, 0, 0, 1, 1'b1));   // empty, zero length
        dir_tab.push_back(row(ACT_WRITE, 128, 128, 1, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(row(ACT_QUERY, 0, 0, 0, 0, 0, 0, 0, 1, 1'b0));
        dir_tab.push_back(row(ACT_QUERY, 0, 0, 0, M1, 0, M1, 0, 1, 1'b1));
        dir_tab.push_back(row(ACT_QUERY, 0, 0, 0, M1N, 0, M1, 0, 1, 1'b0));
        dir_tab.push_back(row(ACT_QUERY, 0, 0, 0, W_MIN, 0, W_MAX, 0, 1, 1'b0));
        dir_tab.push_back(row(ACT_QUERY, 0, 0, 0, 0, W_MIN, 0, W_MAX, 1, 1'b0));
        dir_tab.push_back(row(ACT_WRITE, 128, 128, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(row(ACT_QUERY, 0, 0, 0, M1N, 0, M1, 0, 1, 1'b1));
        dir_tab.push_back(row(ACT_WRITE, 255, 255, 1, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(row(ACT_QUERY, 0, 0, 0, W_MIN, W_MIN, W_MAX, W_MAX, 1, 1'b0));
        dir_tab.push_back(row(ACT_QUERY, 0, 0, 0, W_MAX, W_MAX, W_MAX, W_MAX, 1, 1'b0));
        dir_tab.push_back(row(ACT_QUERY, 0, 0, 0, W_MIN, W_MAX, W_MAX, W_MIN, 0, 0));
        dir_tab.push_back(row(ACT_WRITE, 0, 0, 1, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(row(ACT_QUERY, 0, 0, 0, W_MIN, W_MIN, W_MIN, W_MIN, 1, 1'b0));
        dir_tab.push_back(row(ACT_QUERY, 0, 0, 0, M1, M1, M1N, M1N, 0, 0));  // corner ties
        dir_tab.push_back(row(ACT_WRITE, 128, 130, 1, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(row(ACT_QUERY, 0, 0, 0, 0, 0, 0, M1, 1, 1'b0));    // z motion only
        dir_tab.push_back(row(ACT_QUERY, 0, 0, 0, 0, M1, 0, 0, 1, 1'b0));
        dir_tab.push_back(row(ACT_WRITE, 255, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(row(ACT_WRITE, 0, 255, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(row(ACT_QUERY, 0, 0, 0, 32'h8000, 32'h4000, 32'h3_0000,
                              32'hFFFE_0000, 0, 0));
        foreach (dir_tab[i])
            offer(dir_tab[i], pick_gap());
        drain();

        // Random phases, each under its own register setting
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin w = 256; d = 256; inv = glos_pkg::RST_INV; cx = 0; cz = 0; end
                1: begin w = 1; d = 1; inv = 1; cx = W_MAX; cz = W_MAX; end
                2: begin w = 0; d = 511; inv = 24'hFF_FFFF; cx = W_MIN; cz = W_MIN; end
                3: begin w = 8; d = 5; inv = 0; cx = $urandom; cz = $urandom; end
                4: begin w = 256; d = 256; inv = 3 << 16; cx = M1; cz = M1N; end
                default: begin
                    w   = $urandom_range(1, 40);
                    d   = $urandom_range(1, 40);
                    inv = ($urandom_range(1, 16) << 16) | $urandom_range(0, 16'hFFFF);
                    cx  = $signed($urandom_range(0, 1 << 25)) - (1 << 24);
                    cz  = $signed($urandom_range(0, 1 << 25)) - (1 << 24);
                end
            endcase
            program_regs(w, d, inv, cx, cz);
            for (int i = 0; i < PHASE_LEN; i++) begin
                it = random_item();
                offer(it, (p % 3 == 1) ? 0 : pick_gap());   // some phases run back to back
            end
            drain();
        end

        if (errors == 0 && sight_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

`default_nettype wire
